### hw/rtl/sfe_pkg.sv
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared constants and types of the sbus frame encoder.
// ----------------------------------------------------------------------------
package sfe_pkg;

  localparam int unsigned ChanW  = 12;
  localparam int unsigned SbusW  = 11;
  localparam int unsigned OffW   = 10;
  localparam int unsigned CntW   = 4;
  localparam int unsigned PendW  = 7;
  localparam int unsigned GrpLen = 4;
  localparam int unsigned GrpIdxW = $clog2(GrpLen);
  localparam int unsigned GrpCntW = $clog2(GrpLen + 1);

  localparam logic [ChanW-1:0] ChanMinReset = 12'd1000;
  localparam logic [ChanW:0]   ChanSpan     = 13'd1000;
  localparam logic [OffW-1:0]  OffMax       = 10'd1000;

  // ceil(1.639 * 2^20): exact floor(off * 1639 / 1000) for off up to 1000
  localparam logic [20:0]      ScaleMul     = 21'd1718617;
  localparam int unsigned      ScaleShift   = 20;
  localparam logic [SbusW-1:0] SbusBase     = 11'd173;
  localparam logic [SbusW-1:0] SbusTop      = 11'd1812;

  localparam logic [7:0]       SbusHeader   = 8'h0F;
  localparam logic [7:0]       SbusFooter   = 8'h00;
  localparam int unsigned      FlagFsBit    = 3;
  localparam int unsigned      FlagFlBit    = 2;
  localparam logic [CntW-1:0]  FirstChan    = 4'd0;
  localparam logic [CntW-1:0]  LastChan     = 4'd15;

  typedef struct packed {
    logic [SbusW-1:0] sbus;
    logic             failsafe;
    logic             frame_lost;
  } sfe_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } sfe_byte_t;

endpackage

### hw/rtl/sfe_scale.sv
// ----------------------------------------------------------------------------
// sfe_scale
// Input register, clamp stage and scale stage producing 11-bit sbus values.
// ----------------------------------------------------------------------------
module sfe_scale (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sfe_pkg::ChanW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [sfe_pkg::ChanW-1:0] in_value_i,
  input  logic                      in_failsafe_i,
  input  logic                      in_frame_lost_i,
  output logic                      item_valid_o,
  input  logic                      item_ready_i,
  output sfe_pkg::sfe_item_t        item_o
);
  import sfe_pkg::*;

  logic [ChanW-1:0] min_q;

  logic             vld1_q, vld2_q, vld3_q;
  logic             rdy1, rdy2, rdy3;
  logic [ChanW-1:0] val1_q;
  logic             fs1_q, fl1_q, fs2_q, fl2_q;
  logic [OffW-1:0]  off2_q;
  logic [OffW-1:0]  off_d;
  sfe_item_t        item_q, item_d;

  logic [ChanW:0]   hi;
  logic [ChanW-1:0] diff;
  logic [30:0]      prod;
  logic [SbusW-1:0] quo;

  assign rdy3 = !vld3_q || item_ready_i;
  assign rdy2 = !vld2_q || rdy3;
  assign rdy1 = !vld1_q || rdy2;
  assign in_ready_o = rdy1;

  // clamp to the window and take the offset
  assign hi   = {1'b0, min_q} + ChanSpan;
  assign diff = val1_q - min_q;
  always_comb begin
    if (val1_q < min_q) begin
      off_d = '0;
    end else if ({1'b0, val1_q} > hi) begin
      off_d = OffMax;
    end else begin
      off_d = diff[OffW-1:0];
    end
  end

  // scale by 1639/1000 through a reciprocal multiply
  assign prod = {21'b0, off2_q} * {10'b0, ScaleMul};
  assign quo  = prod[ScaleShift +: SbusW];
  always_comb begin
    item_d.sbus       = quo + SbusBase;
    item_d.failsafe   = fs2_q;
    item_d.frame_lost = fl2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= ChanMinReset;
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_q <= cfg_wdata_i;
      end
      if (rdy1) begin
        vld1_q <= in_valid_i;
      end
      if (rdy2) begin
        vld2_q <= vld1_q;
      end
      if (rdy3) begin
        vld3_q <= vld2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      val1_q <= in_value_i;
      fs1_q  <= in_failsafe_i;
      fl1_q  <= in_frame_lost_i;
    end
    if (rdy2 && vld1_q) begin
      off2_q <= off_d;
      fs2_q  <= fs1_q;
      fl2_q  <= fl1_q;
    end
    if (rdy3 && vld2_q) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = vld3_q;
  assign item_o       = item_q;

  a_off_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld2_q |-> off2_q <= OffMax)
    else $error("offset beyond window span");

  a_sbus_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld3_q |-> (item_q.sbus >= SbusBase && item_q.sbus <= SbusTop))
    else $error("sbus value out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld3_q && !item_ready_i |=> vld3_q && $stable(item_q))
    else $error("scaled item lost under stall");

endmodule

### hw/rtl/sfe_pack.sv
// ----------------------------------------------------------------------------
// sfe_pack
// Bit packer building the byte group of each channel and a byte serializer.
// ----------------------------------------------------------------------------
module sfe_pack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  sfe_pkg::sfe_item_t item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_data_o,
  output logic               out_last_o
);
  import sfe_pkg::*;

  logic [CntW-1:0]    cnt_q;
  logic [PendW-1:0]   pend_q, pend_d;
  logic [2:0]         pcnt_q, pcnt_d;

  sfe_byte_t          grp_q [GrpLen];
  sfe_byte_t          grp_d [GrpLen];
  logic [GrpCntW-1:0] rem_q, num_d;
  logic [GrpIdxW-1:0] idx_q;

  logic               out_vld_q;
  sfe_byte_t          out_q;

  logic [17:0]        acc;
  logic [4:0]         nbits;
  logic               two;
  logic [7:0]         flags;
  logic               load_out, grp_free, take;

  assign acc   = {11'b0, pend_q} | ({7'b0, item_i.sbus} << pcnt_q);
  assign nbits = {2'b0, pcnt_q} + 5'd11;
  assign two   = nbits[4];

  always_comb begin
    flags = 8'h00;
    flags[FlagFsBit] = item_i.failsafe;
    flags[FlagFlBit] = item_i.frame_lost;
  end

  always_comb begin
    num_d = '0;
    for (int i = 0; i < GrpLen; i++) begin
      grp_d[i] = '{data: 8'h00, last: 1'b0};
    end
    if (cnt_q == FirstChan) begin
      grp_d[num_d[GrpIdxW-1:0]] = '{data: SbusHeader, last: 1'b0};
      num_d = num_d + 3'd1;
    end
    grp_d[num_d[GrpIdxW-1:0]] = '{data: acc[7:0], last: 1'b0};
    num_d = num_d + 3'd1;
    if (two) begin
      grp_d[num_d[GrpIdxW-1:0]] = '{data: acc[15:8], last: 1'b0};
      num_d = num_d + 3'd1;
    end
    if (cnt_q == LastChan) begin
      grp_d[num_d[GrpIdxW-1:0]] = '{data: flags, last: 1'b0};
      num_d = num_d + 3'd1;
      grp_d[num_d[GrpIdxW-1:0]] = '{data: SbusFooter, last: 1'b1};
      num_d = num_d + 3'd1;
    end
  end

  always_comb begin
    pend_d = two ? {5'b0, acc[17:16]} : acc[14:8];
    pcnt_d = nbits[2:0];
    if (cnt_q == LastChan) begin
      pend_d = '0;
      pcnt_d = '0;
    end
  end

  assign load_out     = (rem_q != '0) && (!out_vld_q || out_ready_i);
  assign grp_free     = (rem_q == '0) || ((rem_q == 3'd1) && load_out);
  assign item_ready_o = grp_free;
  assign take         = item_valid_i && grp_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      pend_q    <= '0;
      pcnt_q    <= '0;
      rem_q     <= '0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (take) begin
        cnt_q  <= cnt_q + 4'd1;
        pend_q <= pend_d;
        pcnt_q <= pcnt_d;
        rem_q  <= num_d;
        idx_q  <= '0;
      end else if (load_out) begin
        rem_q <= rem_q - 3'd1;
        idx_q <= idx_q + 2'd1;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      grp_q <= grp_d;
    end
    if (load_out) begin
      out_q <= grp_q[idx_q];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q.data;
  assign out_last_o  = out_q.last;

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && cnt_q == LastChan |=> cnt_q == FirstChan && pcnt_q == '0)
    else $error("frame did not wrap to first channel");

  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == FirstChan |-> pcnt_q == '0 && pend_q == '0)
    else $error("leftover bits at frame boundary");

  a_group_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 3'd4)
    else $error("byte group count overflow");

  a_footer_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.last |-> out_q.data == SbusFooter)
    else $error("end of frame on a non-footer byte");

endmodule

### hw/rtl/sbus_frame_encoder.sv
// Path: an accepted transfer passes the input, clamp and scale registers, then the
// group and single-byte output registers. Throughput: one output byte per cycle
// while m_axis_tready is high; a 16-channel frame is 25 bytes, 1 to 4 per item.
// Reset: channel_min returns to 1000, the frame restarts at the first channel
// with no pending bits, and all pipeline and output stages are emptied.
// ----------------------------------------------------------------------------
// sbus_frame_encoder
// Clamps and scales channel values and packs them into 25-byte sbus frames.
// ----------------------------------------------------------------------------
module sbus_frame_encoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sfe_pkg::ChanW-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [11:0] channel_value, [12] failsafe, [13] frame_lost, [15:14] zero
  input  logic [15:0]               s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [7:0] frame_byte
  output logic [7:0]                m_axis_tdata,
  output logic                      m_axis_tlast
);
  import sfe_pkg::*;

  logic      item_valid, item_ready;
  sfe_item_t item;

  sfe_scale u_scale (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .in_value_i      (s_axis_tdata[ChanW-1:0]),
    .in_failsafe_i   (s_axis_tdata[12]),
    .in_frame_lost_i (s_axis_tdata[13]),
    .item_valid_o    (item_valid),
    .item_ready_i    (item_ready),
    .item_o          (item)
  );

  sfe_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

### test/sbus_frame_checker.sv
// ----------------------------------------------------------------------------
// sbus_frame_checker
// Watches the channel and byte streams of the sbus frame encoder, predicts
// every frame byte from the accepted channel transfers and the channel_min
// writes, and compares each output transfer with the oldest predicted byte.
// ----------------------------------------------------------------------------
module sbus_frame_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sfe_pkg::ChanW-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [15:0]               s_axis_tdata,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [7:0]                m_axis_tdata,
  input  logic                      m_axis_tlast,
  output int unsigned               fail_count,
  output int unsigned               bytes_due
);

  localparam int unsigned ScaleNum = 1639;
  localparam int unsigned ScaleDen = 1000;

  logic [sfe_pkg::ChanW-1:0] chan_min;
  logic [sfe_pkg::CntW-1:0]  chan_pos;
  logic [sfe_pkg::PendW-1:0] carry_bits;
  logic [2:0]                carry_cnt;
  sfe_pkg::sfe_byte_t        frame_bytes_q[$];
  sfe_pkg::sfe_byte_t        oldest_byte;

  function automatic logic [sfe_pkg::SbusW-1:0] sbus_code(input logic [11:0] value);
    int unsigned lo;
    int unsigned hi;
    int unsigned v;
    lo = chan_min;
    hi = lo + sfe_pkg::ChanSpan;
    v  = value;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return sfe_pkg::SbusW'((v - lo) * ScaleNum / ScaleDen + sfe_pkg::SbusBase);
  endfunction

  task automatic encode_channel(input logic [11:0] value, input logic fs, input logic fl);
    logic [17:0] acc;
    int unsigned nbits;
    logic [7:0]  flags;
    if (chan_pos == sfe_pkg::FirstChan) frame_bytes_q.push_back({sfe_pkg::SbusHeader, 1'b0});
    acc   = 18'(carry_bits) | (18'(sbus_code(value)) << carry_cnt);
    nbits = carry_cnt + sfe_pkg::SbusW;
    while (nbits >= 8) begin
      frame_bytes_q.push_back({acc[7:0], 1'b0});
      acc   = acc >> 8;
      nbits = nbits - 8;
    end
    carry_bits = acc[6:0];
    carry_cnt  = nbits[2:0];
    if (chan_pos == sfe_pkg::LastChan) begin
      flags = '0;
      flags[sfe_pkg::FlagFsBit] = fs;
      flags[sfe_pkg::FlagFlBit] = fl;
      frame_bytes_q.push_back({flags, 1'b0});
      frame_bytes_q.push_back({sfe_pkg::SbusFooter, 1'b1});
      carry_bits = '0;
      carry_cnt  = '0;
    end
    chan_pos = chan_pos + 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_min   = sfe_pkg::ChanMinReset;
      chan_pos   = '0;
      carry_bits = '0;
      carry_cnt  = '0;
      frame_bytes_q.delete();
      fail_count = 0;
      bytes_due  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_bytes_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected transfer, expected none, got byte %02h last %0b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          oldest_byte = frame_bytes_q.pop_front();
          if (oldest_byte.data !== m_axis_tdata || oldest_byte.last !== m_axis_tlast) begin
            fail_count++;
            $display("%0t: frame byte mismatch, expected %02h last %0b, got %02h last %0b",
                     $time, oldest_byte.data, oldest_byte.last, m_axis_tdata, m_axis_tlast);
          end
        end
      end
      if (cfg_we_i) chan_min = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        encode_channel(s_axis_tdata[11:0], s_axis_tdata[12], s_axis_tdata[13]);
      end
      bytes_due = frame_bytes_q.size();
    end
  end

endmodule

### test/tb_sbus_frame_encoder.sv
// ----------------------------------------------------------------------------
// tb_sbus_frame_encoder
// Drives channel values into the sbus frame encoder: one directed frame with
// the clamp edges and ignored flags, then random channels under several
// channel_min settings (including windows past the input range and writes in
// the middle of a frame), with random stalls on both streams and one long
// output hold-off. A separate checker predicts and compares every byte.
// ----------------------------------------------------------------------------
module tb_sbus_frame_encoder;

  localparam int unsigned HalfPeriod   = 5;
  localparam int unsigned ResetCycles  = 7;
  localparam int unsigned QuietLimit   = 3000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned PhaseItems   = 57;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainCycles  = 20;

  localparam logic [11:0] FirstFrame [16] = '{
    12'd0,    12'd999,  12'd1000, 12'd1001, 12'd1500, 12'd1999, 12'd2000, 12'd2001,
    12'hFFF,  12'd1234, 12'd1777, 12'd1638, 12'd1001, 12'd2999, 12'd1500, 12'd2000
  };

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_we_i      = 1'b0;
  logic [sfe_pkg::ChanW-1:0] cfg_wdata_i   = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [15:0]               s_axis_tdata  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [7:0]                m_axis_tdata;
  logic                      m_axis_tlast;

  int unsigned fail_count;
  int unsigned bytes_due;
  int unsigned quiet_cycles = 0;
  bit          long_hold    = 1'b0;
  bit          steady       = 1'b0;
  logic [11:0] cur_min      = sfe_pkg::ChanMinReset;

  sbus_frame_encoder i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  sbus_frame_checker i_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .fail_count,
    .bytes_due
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // mostly around the clamp window, some edges and some anywhere
  function automatic logic [11:0] pick_value();
    int          lo;
    int          hi;
    int unsigned r;
    lo = int'(cur_min) - 60;
    hi = int'(cur_min) + 1060;
    if (lo < 0) lo = 0;
    if (hi > 4095) hi = 4095;
    r = $urandom_range(0, 99);
    if (r < 70) return 12'($urandom_range(unsigned'(hi), unsigned'(lo)));
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return 12'd0;
        1: return 12'hFFF;
        2: return cur_min;
        default: return (int'(cur_min) + 1000 > 4095) ? 12'hFFF : cur_min + 12'd1000;
      endcase
    end
    return 12'($urandom);
  endfunction

  task automatic send_channel(input logic [11:0] value, input logic fs, input logic fl);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 16'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, fl, fs, value};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_channel_min(input logic [11:0] value);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (bytes_due != 0);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_min = value;
  endtask

  initial begin
    logic [11:0] phase_min [NumPhases];
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // flags on middle channels must be ignored
    for (int i = 0; i < 16; i++) begin
      send_channel(FirstFrame[i], (i == 9) || (i == 15), i == 10);
    end

    phase_min = '{12'd0, 12'd3095, 12'hFFF, 12'($urandom_range(1, 3094)), 12'd3500,
                  sfe_pkg::ChanMinReset};
    for (int p = 0; p < NumPhases; p++) begin
      write_channel_min(phase_min[p]);
      long_hold = (p == 1);
      steady    = (p == 3);
      for (int k = 0; k < PhaseItems; k++) begin
        send_channel(pick_value(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (bytes_due != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && bytes_due == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    repeat (ResetCycles) @(posedge clk_i);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        gap = idle_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

### files.f
hw/rtl/sfe_pkg.sv
hw/rtl/sfe_scale.sv
hw/rtl/sfe_pack.sv
hw/rtl/sbus_frame_encoder.sv
test/sbus_frame_checker.sv
test/tb_sbus_frame_encoder.sv
